FILE: hdl/ffsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and constants of the first-fit segment allocator
// Widths of the item fields, table geometry and the control state encoding.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int SEG_BYTES   = 32;
  localparam int MAX_ENTRIES = 16;

  localparam int OFF_W = 5;              // block offset field
  localparam int LEN_W = 6;              // block length and request size
  localparam int CNT_W = 5;              // entry count field
  localparam int SUM_W = LEN_W + 2;      // room for start + length + size

  localparam logic [SUM_W-1:0] SEG_LIMIT = SUM_W'(SEG_BYTES);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_ENTRIES);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [LEN_W-1:0] alloc_size;
    logic [OFF_W-1:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] block_offset;
    logic [CNT_W-1:0] blocks_in_use;
  } out_item_t;

  // Request broadcast to every cell of the table.
  typedef struct packed {
    logic             alloc_en;
    logic             free_en;
    logic [LEN_W-1:0] size;
    logic [OFF_W-1:0] offset;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

  typedef struct packed {
    logic eval;
    logic apply;
  } cell_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_t;

endpackage

FILE: hdl/ffsa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_cell: one entry of the sorted block table
// Holds one block, checks the gap in front of it or the match of a free, and
// shifts with its neighbors on insert or delete.
// ----------------------------------------------------------------------------
module ffsa_cell (
  input  logic                        clk,
  input  ffsa_pkg::cell_phase_t       phase,
  input  ffsa_pkg::cell_ctl_t         ctl,
  input  logic [ffsa_pkg::CNT_W-1:0]  cell_index,
  input  logic [ffsa_pkg::OFF_W-1:0]  prev_start,
  input  logic [ffsa_pkg::LEN_W-1:0]  prev_len,
  input  logic [ffsa_pkg::OFF_W-1:0]  next_start,
  input  logic [ffsa_pkg::LEN_W-1:0]  next_len,
  input  logic                        any_in,
  input  logic [ffsa_pkg::OFF_W-1:0]  sel_in,
  output logic [ffsa_pkg::OFF_W-1:0]  start,
  output logic [ffsa_pkg::LEN_W-1:0]  len,
  output logic                        any_out,
  output logic [ffsa_pkg::OFF_W-1:0]  sel_out
);

  logic [ffsa_pkg::SUM_W-1:0] prev_end;
  logic [ffsa_pkg::SUM_W-1:0] bound;
  logic                       valid;
  logic                       tail;
  logic                       fit;
  logic                       match;
  logic                       hit;
  logic [ffsa_pkg::OFF_W-1:0] base;

  // The neighbor of the first cell is tied to zero, so its gap starts at 0.
  assign prev_end = ffsa_pkg::SUM_W'(prev_start) + ffsa_pkg::SUM_W'(prev_len);
  assign valid    = cell_index < ctl.count;
  assign tail     = cell_index == ctl.count;
  // The cell just past the last block checks the gap up to the segment end.
  assign bound    = valid ? ffsa_pkg::SUM_W'(start) : ffsa_pkg::SEG_LIMIT;
  assign fit      = ctl.alloc_en && (valid || tail) &&
                    (bound >= prev_end + ffsa_pkg::SUM_W'(ctl.size));
  assign match    = ctl.free_en && valid && (start == ctl.offset);

  always_ff @(posedge clk) begin
    if (phase.eval) begin
      hit  <= fit || match;
      base <= prev_end[ffsa_pkg::OFF_W-1:0];
    end
  end

  // Only the first hit in offset order counts.
  assign any_out = any_in || hit;
  assign sel_out = any_in ? sel_in : (hit ? base : '0);

  always_ff @(posedge clk) begin
    if (phase.apply) begin
      if (ctl.alloc_en) begin
        if (any_in) begin
          start <= prev_start;
          len   <= prev_len;
        end else if (hit) begin
          start <= base;
          len   <= ctl.size;
        end
      end else if (ctl.free_en && (any_in || hit)) begin
        start <= next_start;
        len   <= next_len;
      end
    end
  end

endmodule

FILE: hdl/first_fit_segment_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit: first-fit allocator over a small segment
// A row of table cells checks every gap or match in the check pass, then inserts
// or deletes with a one-position shift in the apply pass.
// ----------------------------------------------------------------------------
// The result item is registered in the apply state, which follows the gap
// check state after the input item is accepted; apply waits for a held result.
// A new item is taken only in idle or when apply completes, so the check and
// apply passes over the cell row never overlap between items.
// Reset clears the entry count and control; table contents stay undefined.
module first_fit_segment_allocator_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ffsa_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ffsa_pkg::out_item_t  out_item
);

  ffsa_pkg::state_t            state;
  ffsa_pkg::state_t            state_next;
  ffsa_pkg::in_item_t          req;
  logic [ffsa_pkg::CNT_W-1:0]  count;
  logic [ffsa_pkg::CNT_W-1:0]  count_next;
  ffsa_pkg::cell_ctl_t         ctl;
  ffsa_pkg::cell_phase_t       phase;
  logic                        advance;
  logic                        accept;

  logic [ffsa_pkg::OFF_W-1:0]  cell_start [ffsa_pkg::MAX_ENTRIES];
  logic [ffsa_pkg::LEN_W-1:0]  cell_len   [ffsa_pkg::MAX_ENTRIES];
  logic                        chain_any  [ffsa_pkg::MAX_ENTRIES+1];
  logic [ffsa_pkg::OFF_W-1:0]  chain_sel  [ffsa_pkg::MAX_ENTRIES+1];

  assign advance = !out_valid || out_ready;
  assign accept  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ffsa_pkg::ST_IDLE:  if (in_valid) state_next = ffsa_pkg::ST_EVAL;
      ffsa_pkg::ST_EVAL:  state_next = ffsa_pkg::ST_APPLY;
      ffsa_pkg::ST_APPLY: begin
        if (advance) state_next = in_valid ? ffsa_pkg::ST_EVAL : ffsa_pkg::ST_IDLE;
      end
      default:            state_next = ffsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    phase.eval  = 1'b0;
    phase.apply = 1'b0;
    case (state)
      ffsa_pkg::ST_IDLE:  in_ready = 1'b1;
      ffsa_pkg::ST_EVAL:  phase.eval = 1'b1;
      ffsa_pkg::ST_APPLY: begin
        in_ready    = advance;
        phase.apply = advance;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_item;
    end
  end

  assign ctl.alloc_en = (req.req_type == ffsa_pkg::REQ_ALLOC) &&
                        (req.alloc_size != '0) &&
                        (ffsa_pkg::SUM_W'(req.alloc_size) <= ffsa_pkg::SEG_LIMIT) &&
                        (count < ffsa_pkg::CNT_FULL);
  assign ctl.free_en  = req.req_type == ffsa_pkg::REQ_FREE;
  assign ctl.size     = req.alloc_size;
  assign ctl.offset   = req.free_offset;
  assign ctl.count    = count;

  assign chain_any[0] = 1'b0;
  assign chain_sel[0] = '0;

  for (genvar i = 0; i < ffsa_pkg::MAX_ENTRIES; i++) begin : g_cell
    logic [ffsa_pkg::OFF_W-1:0] p_start;
    logic [ffsa_pkg::LEN_W-1:0] p_len;
    logic [ffsa_pkg::OFF_W-1:0] n_start;
    logic [ffsa_pkg::LEN_W-1:0] n_len;

    if (i == 0) begin : g_first
      assign p_start = '0;
      assign p_len   = '0;
    end else begin : g_mid
      assign p_start = cell_start[i-1];
      assign p_len   = cell_len[i-1];
    end

    if (i == ffsa_pkg::MAX_ENTRIES - 1) begin : g_last
      assign n_start = cell_start[i];
      assign n_len   = cell_len[i];
    end else begin : g_inner
      assign n_start = cell_start[i+1];
      assign n_len   = cell_len[i+1];
    end

    ffsa_cell u_cell (
      .clk        (clk),
      .phase      (phase),
      .ctl        (ctl),
      .cell_index (ffsa_pkg::CNT_W'(i)),
      .prev_start (p_start),
      .prev_len   (p_len),
      .next_start (n_start),
      .next_len   (n_len),
      .any_in     (chain_any[i]),
      .sel_in     (chain_sel[i]),
      .start      (cell_start[i]),
      .len        (cell_len[i]),
      .any_out    (chain_any[i+1]),
      .sel_out    (chain_sel[i+1])
    );
  end

  always_comb begin
    count_next = count;
    if (chain_any[ffsa_pkg::MAX_ENTRIES]) begin
      if (ctl.alloc_en) begin
        count_next = count + 1'b1;
      end else if (ctl.free_en) begin
        count_next = count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (phase.apply) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (phase.apply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (phase.apply) begin
      out_item.ok            <= chain_any[ffsa_pkg::MAX_ENTRIES];
      out_item.block_offset  <= ctl.alloc_en ? chain_sel[ffsa_pkg::MAX_ENTRIES] : '0;
      out_item.blocks_in_use <= count_next;
    end
  end

endmodule
